[rtl/stc_pkg.sv]
// ----------------------------------------------------------------------------
// stc_pkg - spaces to tabs converter shared definitions
// Character codes, register map, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  localparam logic [6:0] DEFAULT_TAB = 7'd8;
  localparam logic [6:0] MAX_TAB     = 7'd64;

  localparam int ADDR_W = 3;

  localparam logic REG_TAB_WIDTH = 1'b0;
  localparam logic REG_CONVERT   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FLUSH,
    S_FINAL
  } state_t;

  typedef enum logic [1:0] {
    SEL_DIRECT,
    SEL_SPACE,
    SEL_PENDING
  } out_sel_t;

  typedef struct packed {
    logic       tab_width_zero;
    logic [6:0] tab_width;
    logic       convert_all_blanks;
  } cfg_t;

  typedef struct packed {
    logic     take;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
    logic     dec_held;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic needs_flush;
    logic has_final;
    logic held_one;
    logic held_zero;
    logic pend_final;
  } dp_status_t;

endpackage

[rtl/stc_regs.sv]
// ----------------------------------------------------------------------------
// stc_regs - configuration registers
// APB-style register file holding the tab width and the conversion mode.
// ----------------------------------------------------------------------------
module stc_regs
  import stc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [6:0] tab_width;
  logic       convert_all_blanks;
  logic       wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width          <= DEFAULT_TAB;
      convert_all_blanks <= 1'b0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_TAB_WIDTH: tab_width          <= pwdata[6:0];
        REG_CONVERT:   convert_all_blanks <= pwdata[0];
        default:       tab_width          <= tab_width;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TAB_WIDTH: prdata = {25'd0, tab_width};
      REG_CONVERT:   prdata = {31'd0, convert_all_blanks};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg.tab_width_zero     = (tab_width == 7'd0);
  assign cfg.tab_width          = tab_width;
  assign cfg.convert_all_blanks = convert_all_blanks;

endmodule

[rtl/stc_datapath.sv]
// ----------------------------------------------------------------------------
// stc_datapath - converter datapath
// Line position, held space count, leading flag, pending byte and the
// output register.
// ----------------------------------------------------------------------------
module stc_datapath
  import stc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic [7:0] in_char,
  input  logic       end_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_of_run,
  input  ctrl_cmd_t  cmd,
  output dp_status_t sts
);

  logic [5:0] stop_position;
  logic [5:0] held_spaces;
  logic       past_leading;
  logic [7:0] pend_char;
  logic       pend_final;

  logic [6:0] eff_width;
  logic [6:0] next_pos;
  logic       reach;
  logic       conv_space;
  logic       has_final;
  logic [7:0] final_char;
  logic [7:0] out_char_next;

  always_comb begin
    if (cfg.tab_width_zero) begin
      eff_width = DEFAULT_TAB;
    end else if (cfg.tab_width > MAX_TAB) begin
      eff_width = MAX_TAB;
    end else begin
      eff_width = cfg.tab_width;
    end
  end

  assign next_pos   = {1'b0, stop_position} + 7'd1;
  assign reach      = (next_pos >= eff_width);
  assign conv_space = !end_of_stream && (in_char == CH_SPACE) &&
                      (cfg.convert_all_blanks || !past_leading);
  assign has_final  = conv_space ? reach : !end_of_stream;
  assign final_char = conv_space ? CH_TAB : in_char;

  assign sts.slot_free   = !out_valid || out_ready;
  assign sts.needs_flush = !conv_space && (held_spaces != 6'd0);
  assign sts.has_final   = has_final;
  assign sts.held_one    = (held_spaces == 6'd1);
  assign sts.held_zero   = (held_spaces == 6'd0);
  assign sts.pend_final  = pend_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_position <= 6'd0;
      held_spaces   <= 6'd0;
      past_leading  <= 1'b0;
      pend_final    <= 1'b0;
    end else if (cmd.take) begin
      pend_final <= has_final;
      if (end_of_stream) begin
        stop_position <= 6'd0;
        past_leading  <= 1'b0;
      end else if (conv_space) begin
        held_spaces   <= reach ? 6'd0 : held_spaces + 6'd1;
        stop_position <= reach ? 6'd0 : next_pos[5:0];
      end else if (in_char == CH_NEWLINE) begin
        stop_position <= 6'd0;
        past_leading  <= 1'b0;
      end else if (in_char == CH_TAB) begin
        stop_position <= 6'd0;
      end else begin
        stop_position <= reach ? 6'd0 : next_pos[5:0];
        if (in_char != CH_SPACE) begin
          past_leading <= 1'b1;
        end
      end
    end else if (cmd.dec_held) begin
      held_spaces <= held_spaces - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_char <= in_char;
    end
  end

  always_comb begin
    case (cmd.out_sel)
      SEL_DIRECT:  out_char_next = final_char;
      SEL_SPACE:   out_char_next = CH_SPACE;
      SEL_PENDING: out_char_next = pend_char;
      default:     out_char_next = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_char    <= out_char_next;
      last_of_run <= cmd.out_last;
    end
  end

endmodule

[rtl/stc_ctrl.sv]
// ----------------------------------------------------------------------------
// stc_ctrl - converter controller
// Accepts requests, sequences held space release and the final byte.
// ----------------------------------------------------------------------------
module stc_ctrl
  import stc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && sts.slot_free && sts.needs_flush) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (sts.slot_free && sts.held_one) begin
          state_next = sts.pend_final ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        if (sts.slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.take     = 1'b0;
    cmd.out_load = 1'b0;
    cmd.out_sel  = SEL_DIRECT;
    cmd.out_last = 1'b1;
    cmd.dec_held = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = sts.slot_free;
        cmd.take = in_valid && sts.slot_free;
        if (in_valid && sts.slot_free && !sts.needs_flush && sts.has_final) begin
          cmd.out_load = 1'b1;
        end
      end
      S_FLUSH: begin
        cmd.out_sel = SEL_SPACE;
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = sts.held_one && !sts.pend_final;
          cmd.dec_held = 1'b1;
        end
      end
      S_FINAL: begin
        cmd.out_sel  = SEL_PENDING;
        cmd.out_load = sts.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTH
  a_flush_has_spaces: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> !sts.held_zero)
    else $error("release in progress with no held spaces");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.slot_free)
    else $error("output register overwritten before delivery");

  a_flush_follows_take: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && sts.needs_flush) |=> (state == S_FLUSH))
    else $error("held spaces not released after request");

  a_final_needs_byte: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL) |-> sts.pend_final)
    else $error("final byte stage entered without a pending byte");
`endif

endmodule

[rtl/spaces_to_tabs_converter_unit.sv]
// ----------------------------------------------------------------------------
// spaces_to_tabs_converter_unit - spaces to tabs converter top level
// Timing: a result appears in the cycle after its request is accepted; a
//   request that releases held spaces gives them through S_FLUSH and its byte through S_FINAL.
// Throughput: one request per cycle while no held spaces are released and
//   the output is not stalled; no request is taken while held spaces are
//   released, one result per cycle through the output register when not stalled.
// Reset: synchronous; clears position, held count and leading flag, sets
//   tab width to 8 and leading-only conversion.
// ----------------------------------------------------------------------------
module spaces_to_tabs_converter_unit
  import stc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char,
  input  logic              end_of_stream,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              last_of_run
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t sts;

  stc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_char       (in_char),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .last_of_run   (last_of_run),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

[verif/stc_checker.sv]
// ----------------------------------------------------------------------------
// stc_checker - result checker for the spaces to tabs converter
// Watches the register port and both byte channels, keeps its own copy of
// tab position, held spaces and leading flag, and compares every accepted
// output byte and its end-of-run flag against the predicted sequence.
// ----------------------------------------------------------------------------
module stc_checker
  import stc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_char,
  input  logic              end_of_stream,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_char,
  input  logic              last_of_run,
  output int                errors,
  output int                outstanding,
  output int                checked
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  logic [6:0] tab_width;
  logic       convert_all;
  logic [5:0] stop_pos;
  logic [5:0] held;
  logic       past_leading;

  text_byte_t expected_bytes[$];

  task automatic queue_byte(input logic [7:0] ch);
    text_byte_t b;
    b.ch = ch;
    b.last = 1'b0;
    expected_bytes.push_back(b);
  endtask

  task automatic release_held();
    while (held != 6'd0) begin
      queue_byte(CH_SPACE);
      held = held - 6'd1;
    end
  endtask

  task automatic unexpand_request(input logic [7:0] ch, input logic eos);
    logic [6:0] width;
    logic [6:0] next_pos;
    int         first;
    width = (tab_width == 7'd0) ? DEFAULT_TAB : ((tab_width > MAX_TAB) ? MAX_TAB : tab_width);
    next_pos = {1'b0, stop_pos} + 7'd1;
    first = expected_bytes.size();
    if (eos) begin
      release_held();
      stop_pos = 6'd0;
      past_leading = 1'b0;
    end else if (ch == CH_SPACE && (convert_all || !past_leading)) begin
      held = held + 6'd1;
      if (next_pos >= width) begin
        queue_byte(CH_TAB);
        held = 6'd0;
        stop_pos = 6'd0;
      end else begin
        stop_pos = next_pos[5:0];
      end
    end else begin
      release_held();
      queue_byte(ch);
      if (ch == CH_NEWLINE) begin
        stop_pos = 6'd0;
        past_leading = 1'b0;
      end else if (ch == CH_TAB) begin
        stop_pos = 6'd0;
      end else begin
        if (ch != CH_SPACE) past_leading = 1'b1;
        stop_pos = (next_pos >= width) ? 6'd0 : next_pos[5:0];
      end
    end
    if (expected_bytes.size() > first) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tab_width = DEFAULT_TAB;
      convert_all = 1'b0;
      stop_pos = 6'd0;
      held = 6'd0;
      past_leading = 1'b0;
      expected_bytes.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: out_char %0h last_of_run %0b", out_char, last_of_run);
          errors++;
        end else begin
          if (out_char !== expected_bytes[0].ch) begin
            $error("out_char mismatch: expected %0h, actual %0h",
                   expected_bytes[0].ch, out_char);
            errors++;
          end
          if (last_of_run !== expected_bytes[0].last) begin
            $error("last_of_run mismatch: expected %0b, actual %0b",
                   expected_bytes[0].last, last_of_run);
            errors++;
          end
          void'(expected_bytes.pop_front());
          checked++;
        end
      end
      if (in_valid && in_ready) unexpand_request(in_char, end_of_stream);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TAB_WIDTH) tab_width = pwdata[6:0];
        else convert_all = pwdata[0];
      end
    end
    outstanding = expected_bytes.size();
  end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - testbench for the spaces to tabs converter
// Drives directed and random text streams through the converter under
// several tab widths and both conversion modes, with random stalls on both
// channels and a long output hold-off; the checker predicts every byte.
// ----------------------------------------------------------------------------
module tb_top
  import stc_pkg::*;
();

  localparam int PERIOD         = 20;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int HOLD_CYCLES    = 150;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_REQUESTS = 20;
  localparam int NUM_PHASES     = 8;

  localparam logic [ADDR_W-1:0] ADDR_TAB_WIDTH = {REG_TAB_WIDTH, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_CONVERT   = {REG_CONVERT, 2'b00};

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [7:0]        in_char       = 8'd0;
  logic              end_of_stream = 1'b0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [7:0]        out_char;
  logic              last_of_run;

  int errors;
  int outstanding;
  int checked;
  int send_idle     = 35;
  int recv_idle     = 51;
  bit hold_off      = 1'b0;
  int requests_sent = 0;
  int cycles        = 0;

  spaces_to_tabs_converter_unit i_dut (.*);

  stc_checker i_checker (.*);

  always #(PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= TIMEOUT_CYCLES) begin
      $display("FAIL spaces_to_tabs_converter_unit");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] ch, input logic eos);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char <= ch;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int         widths[NUM_PHASES] = '{1, 8, 64, 0, 5, 127, 3, 16};
    bit         modes[NUM_PHASES]  = '{0, 1, 0, 1, 1, 0, 0, 1};
    int         eff;
    int         sent;
    int         run;
    int         pick;
    int         directed;
    bit         paused;
    logic [7:0] rnd;

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // leading run reaching the stop, then release before a word
    repeat (8) send_byte(CH_SPACE, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(8'h61, 1'b0);
    // past leading: plain space
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CH_NEWLINE, 1'b0);
    // end of stream with and without held spaces
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b1);
    wait_drained();
    // shrink the width mid-line past the current position
    apb_write(ADDR_TAB_WIDTH, 32'd64);
    repeat (5) send_byte(CH_SPACE, 1'b0);
    wait_drained();
    apb_write(ADDR_TAB_WIDTH, 32'd2);
    send_byte(CH_SPACE, 1'b0);
    wait_drained();
    directed = requests_sent;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 3) begin
        send_idle = 35;
        recv_idle = 51;
      end else if (p < 6) begin
        send_idle = 51;
        recv_idle = 35;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      apb_write(ADDR_TAB_WIDTH, widths[p]);
      apb_write(ADDR_CONVERT, {31'd0, modes[p]});
      eff = (widths[p] == 0) ? 8 : ((widths[p] > 64) ? 64 : widths[p]);
      if (p == 2) hold_off = 1'b1;
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_REQUESTS) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          run = $urandom_range(1) ? $urandom_range(1, eff + 1) : $urandom_range(1, 3);
          repeat (run) send_byte(CH_SPACE, 1'b0);
          sent += run;
        end else if (pick < 75) begin
          run = $urandom_range(1, 4);
          repeat (run) begin
            rnd = 8'($urandom_range(255));
            send_byte(rnd, 1'b0);
          end
          sent += run;
        end else if (pick < 85) begin
          send_byte(CH_TAB, 1'b0);
          sent++;
        end else if (pick < 94) begin
          send_byte(CH_NEWLINE, 1'b0);
          sent++;
        end else begin
          rnd = 8'($urandom_range(255));
          send_byte(rnd, 1'b1);
          sent++;
        end
        if (p == 4 && sent >= PHASE_REQUESTS / 2 && !paused) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      wait_drained();
    end

    $display("Sent %0d requests (%0d directed) and checked %0d result bytes",
             requests_sent, directed, checked);
    $display("Tab widths 0 to 127 incl. saturation, both conversion modes, stalls and hold-off");
    if (errors == 0 && outstanding == 0) begin
      $display("PASS spaces_to_tabs_converter_unit");
    end else begin
      $display("FAIL spaces_to_tabs_converter_unit");
    end
    $finish;
  end

endmodule

[spaces_to_tabs_converter_unit.f]
rtl/stc_pkg.sv
rtl/stc_regs.sv
rtl/stc_datapath.sv
rtl/stc_ctrl.sv
rtl/spaces_to_tabs_converter_unit.sv
verif/stc_checker.sv
verif/tb_top.sv
